@@ rtl/sparse_cell_lookup_sum_assert.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef SPARSE_CELL_LOOKUP_SUM_ASSERT_SVH
`define SPARSE_CELL_LOOKUP_SUM_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, idle during reset.
`define SCLS_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication, also checked across reset.
`define SCLS_ASSERT_NEXT(lbl, clk, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define SCLS_ASSERT_IMP(lbl, clk, rst, a, b)
`define SCLS_ASSERT_NEXT(lbl, clk, a, b)
`endif
`endif

@@ rtl/sclsum_pkg.sv @@
package sclsum_pkg;

  localparam int VALUE_W = 48;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [4:0] SHIFT_RESET = 5'd12;

  localparam logic signed [VALUE_W-1:0] SUM_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] SUM_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_CLEAR,
    OP_NONE
  } op_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    op_t                       kind;
    logic [31:0]               position;
    logic [31:0]               seg;
    logic                      seg_ok;
    logic [1:0]                mi;
    logic                      mi_ok;
    logic signed [VALUE_W-1:0] value;
    logic                      value_null;
    logic                      last;
  } item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOAD_SEG,
    ST_Q_SEG,
    ST_Q_SEARCH,
    ST_Q_HIT,
    ST_Q_DONE
  } state_t;

endpackage

@@ rtl/sparse_cell_lookup_sum.sv @@
// Load: a measure of the last cell is written from IDLE, a new cell through LOAD_SEG.
// Clear: a pass over the segment table in INIT. Query: Q_SEG, then Q_SEARCH reads one
// position per cycle from the position memory, then Q_HIT on a match and Q_DONE.
// A result is registered in Q_DONE for the last query item once the output is free.
// Reset (synchronous, active high) clears control state, then the segment table is
// cleared in a pass over all SEGMENTS entries during which full stays high.
module sparse_cell_lookup_sum #(
  parameter int CELL_ENTRIES    = 4096,
  parameter int SEGMENTS        = 64,
  parameter int VALUES_PER_CELL = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic [1:0]                            func,
  input  logic [31:0]                           position,
  input  logic [1:0]                            measure_index,
  input  logic signed [sclsum_pkg::VALUE_W-1:0] value,
  input  logic                                  value_is_null,
  input  logic                                  last_of_query,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [sclsum_pkg::VALUE_W-1:0] sum,
  output logic                                  sum_is_null,
  output logic                                  sum_saturated,
  input  logic                                  cfg_we,
  input  logic [4:0]                            cfg_wdata
);

  `include "sparse_cell_lookup_sum_assert.svh"

  logic [4:0]        segment_shift;
  logic              busy_init;
  logic              q_push, q_full, q_pop, q_empty;
  sclsum_pkg::item_t q_in, q_out;

  // Segment shift register.
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_shift <= sclsum_pkg::SHIFT_RESET;
    end else if (cfg_we) begin
      segment_shift <= cfg_wdata;
    end
  end

  sclsum_front #(
    .SEGMENTS        (SEGMENTS),
    .VALUES_PER_CELL (VALUES_PER_CELL)
  ) u_front (
    .push          (push),
    .full          (full),
    .func          (func),
    .position      (position),
    .measure_index (measure_index),
    .value         (value),
    .value_is_null (value_is_null),
    .last_of_query (last_of_query),
    .segment_shift (segment_shift),
    .busy_init     (busy_init),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  sclsum_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_in    (q_in),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_out   (q_out),
    .q_empty (q_empty)
  );

  sclsum_back #(
    .CELL_ENTRIES    (CELL_ENTRIES),
    .SEGMENTS        (SEGMENTS),
    .VALUES_PER_CELL (VALUES_PER_CELL)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_item        (q_out),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .busy_init     (busy_init),
    .empty         (empty),
    .pop           (pop),
    .sum           (sum),
    .sum_is_null   (sum_is_null),
    .sum_saturated (sum_saturated)
  );

  // The back never takes from an empty queue.
  `SCLS_ASSERT_IMP(a_pop_nonempty, clk, rst, q_pop, !q_empty)
  // No item is accepted while the segment table is being cleared.
  `SCLS_ASSERT_IMP(a_init_blocks, clk, rst, busy_init, full && !q_push)
  // Reset always starts the clearing pass.
  `SCLS_ASSERT_NEXT(a_reset_init, clk, rst, busy_init)

endmodule

@@ rtl/sclsum_front.sv @@
module sclsum_front #(
  parameter int SEGMENTS        = 64,
  parameter int VALUES_PER_CELL = 4
) (
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         func,
  input  logic [31:0]                        position,
  input  logic [1:0]                         measure_index,
  input  logic signed [sclsum_pkg::VALUE_W-1:0] value,
  input  logic                               value_is_null,
  input  logic                               last_of_query,
  input  logic [4:0]                         segment_shift,
  input  logic                               busy_init,
  input  logic                               q_full,
  output logic                               q_push,
  output sclsum_pkg::item_t                  q_item
);

  logic [31:0] seg;

  // Hold off new items while the queue is full or the store is being cleared.
  assign full   = q_full || busy_init;
  assign q_push = push && !full;
  assign seg    = position >> segment_shift;

  // Classify the item and check its segment and measure ranges.
  always_comb begin
    q_item.position   = position;
    q_item.seg        = seg;
    q_item.seg_ok     = seg < 32'(SEGMENTS);
    q_item.mi         = measure_index;
    q_item.mi_ok      = 32'(measure_index) < 32'(VALUES_PER_CELL);
    q_item.value      = value;
    q_item.value_null = value_is_null;
    q_item.last       = last_of_query;
    case (func)
      sclsum_pkg::FUNC_LOAD: begin
        q_item.kind = sclsum_pkg::OP_LOAD;
      end
      sclsum_pkg::FUNC_QUERY: begin
        q_item.kind = sclsum_pkg::OP_QUERY;
      end
      sclsum_pkg::FUNC_CLEAR: begin
        q_item.kind = sclsum_pkg::OP_CLEAR;
      end
      default: begin
        q_item.kind = sclsum_pkg::OP_NONE;
      end
    endcase
  end

endmodule

@@ rtl/sclsum_queue.sv @@
module sclsum_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_push,
  input  sclsum_pkg::item_t q_in,
  output logic              q_full,
  input  logic              q_pop,
  output sclsum_pkg::item_t q_out,
  output logic              q_empty
);

  sclsum_pkg::item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = count == 2'd2;
  assign q_empty = count == 2'd0;
  assign q_out   = slot[rd_ptr];

  // Two-entry queue between the front and the back.
  always_ff @(posedge clk) begin
    if (q_push) begin
      slot[wr_ptr] <= q_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(q_push) - 2'(q_pop);
    end
  end

endmodule

@@ rtl/sclsum_back.sv @@
module sclsum_back #(
  parameter int CELL_ENTRIES    = 4096,
  parameter int SEGMENTS        = 64,
  parameter int VALUES_PER_CELL = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sclsum_pkg::item_t                     q_item,
  input  logic                                  q_empty,
  output logic                                  q_pop,
  output logic                                  busy_init,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [sclsum_pkg::VALUE_W-1:0] sum,
  output logic                                  sum_is_null,
  output logic                                  sum_saturated
);

  localparam int EW  = (CELL_ENTRIES > 1) ? $clog2(CELL_ENTRIES) : 1;
  localparam int CW  = $clog2(CELL_ENTRIES + 1);
  localparam int SW  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int VW  = (VALUES_PER_CELL > 1) ? $clog2(VALUES_PER_CELL) : 1;
  localparam int VAW = (CELL_ENTRIES * VALUES_PER_CELL > 1) ?
                       $clog2(CELL_ENTRIES * VALUES_PER_CELL) : 1;
  localparam int DW  = sclsum_pkg::VALUE_W;

  // Memories: segment table, cell positions, written-measure masks, values.
  logic [EW+CW-1:0]          seg_mem  [SEGMENTS];
  logic [31:0]               pos_mem  [CELL_ENTRIES];
  logic [VALUES_PER_CELL-1:0] mask_mem [CELL_ENTRIES];
  logic [DW:0]               val_mem  [CELL_ENTRIES * VALUES_PER_CELL];

  logic [EW+CW-1:0]           seg_rd;
  logic [31:0]                pos_rd;
  logic [VALUES_PER_CELL-1:0] mask_rd;
  logic [DW:0]                val_rd;

  logic [SW-1:0]              seg_raddr;
  logic [EW-1:0]              pos_raddr;
  logic [VAW-1:0]             val_raddr;
  logic                       seg_we;
  logic [SW-1:0]              seg_waddr;
  logic [EW+CW-1:0]           seg_wdata;
  logic                       pos_we;
  logic                       mask_we;
  logic [EW-1:0]              mask_waddr;
  logic [VALUES_PER_CELL-1:0] mask_wdata;
  logic                       val_we;
  logic [VAW-1:0]             val_waddr;

  sclsum_pkg::state_t state, state_next;
  sclsum_pkg::item_t  cur, cur_next;
  logic [SW-1:0]              clr_cnt, clr_cnt_next;
  logic [CW-1:0]              entries_used, entries_used_next;
  logic [31:0]                last_pos, last_pos_next;
  logic                       any_loaded, any_loaded_next;
  logic [VALUES_PER_CELL-1:0] cur_mask, cur_mask_next;
  logic [CW-1:0]              lo, lo_next, hi, hi_next;
  logic [EW-1:0]              mid, mid_next;
  logic signed [DW-1:0]       run_sum, run_sum_next;
  logic                       run_found, run_found_next;
  logic                       run_sat, run_sat_next;
  logic                       out_valid, out_valid_next;
  logic signed [DW-1:0]       out_sum, out_sum_next;
  logic                       out_null, out_null_next;
  logic                       out_sat, out_sat_next;

  // Decoded helpers.
  logic [VW-1:0]              in_mi, cur_mi;
  logic [SW-1:0]              in_seg, cur_seg;
  logic [VALUES_PER_CELL-1:0] in_bit, cur_bit;
  logic [EW-1:0]              last_entry, new_entry;
  logic [EW-1:0]              seg_first;
  logic [CW-1:0]              seg_count;
  logic [CW:0]                seg_end;
  logic [CW-1:0]              step_lo, step_hi, step_mid;
  logic                       go_low;
  logic [DW:0]                add_full;

  assign in_mi      = VW'(q_item.mi);
  assign cur_mi     = VW'(cur.mi);
  assign in_seg     = q_item.seg[SW-1:0];
  assign cur_seg    = cur.seg[SW-1:0];
  assign in_bit     = VALUES_PER_CELL'(1) << in_mi;
  assign cur_bit    = VALUES_PER_CELL'(1) << cur_mi;
  assign last_entry = EW'(entries_used - CW'(1));
  assign new_entry  = EW'(entries_used);
  assign seg_first  = seg_rd[EW+CW-1:CW];
  assign seg_count  = seg_rd[CW-1:0];
  assign seg_end    = (CW+1)'(seg_first) + (CW+1)'(seg_count);
  assign go_low     = cur.position < pos_rd;
  assign step_lo    = go_low ? lo : CW'(mid) + CW'(1);
  assign step_hi    = go_low ? CW'(mid) : hi;
  assign step_mid   = step_lo + ((step_hi - step_lo) >> 1);
  assign add_full   = {run_sum[DW-1], run_sum} + {val_rd[DW-1], val_rd[DW-1:0]};

  assign busy_init     = state == sclsum_pkg::ST_INIT;
  assign empty         = !out_valid;
  assign sum           = out_sum;
  assign sum_is_null   = out_null;
  assign sum_saturated = out_sat;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sclsum_pkg::ST_INIT: begin
        if (clr_cnt == SW'(SEGMENTS - 1)) begin
          state_next = sclsum_pkg::ST_IDLE;
        end
      end
      sclsum_pkg::ST_IDLE: begin
        if (!q_empty) begin
          case (q_item.kind)
            sclsum_pkg::OP_LOAD: begin
              if (q_item.mi_ok && !(any_loaded && q_item.position == last_pos) &&
                  !(any_loaded && q_item.position < last_pos) && q_item.seg_ok &&
                  entries_used != CW'(CELL_ENTRIES)) begin
                state_next = sclsum_pkg::ST_LOAD_SEG;
              end
            end
            sclsum_pkg::OP_QUERY: begin
              if (q_item.seg_ok && q_item.mi_ok) begin
                state_next = sclsum_pkg::ST_Q_SEG;
              end else begin
                state_next = sclsum_pkg::ST_Q_DONE;
              end
            end
            sclsum_pkg::OP_CLEAR: begin
              state_next = sclsum_pkg::ST_INIT;
            end
            default: begin
              state_next = sclsum_pkg::ST_IDLE;
            end
          endcase
        end
      end
      sclsum_pkg::ST_LOAD_SEG: begin
        state_next = sclsum_pkg::ST_IDLE;
      end
      sclsum_pkg::ST_Q_SEG: begin
        if (seg_count == '0 || seg_end > (CW+1)'(entries_used)) begin
          state_next = sclsum_pkg::ST_Q_DONE;
        end else begin
          state_next = sclsum_pkg::ST_Q_SEARCH;
        end
      end
      sclsum_pkg::ST_Q_SEARCH: begin
        if (pos_rd == cur.position) begin
          state_next = sclsum_pkg::ST_Q_HIT;
        end else if (!(step_lo < step_hi)) begin
          state_next = sclsum_pkg::ST_Q_DONE;
        end
      end
      sclsum_pkg::ST_Q_HIT: begin
        state_next = sclsum_pkg::ST_Q_DONE;
      end
      sclsum_pkg::ST_Q_DONE: begin
        if (!cur.last || !out_valid || pop) begin
          state_next = sclsum_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sclsum_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath controls and register updates.
  always_comb begin
    q_pop             = 1'b0;
    seg_raddr         = cur_seg;
    pos_raddr         = mid;
    val_raddr         = VAW'(mid) * VAW'(VALUES_PER_CELL) + VAW'(cur_mi);
    seg_we            = 1'b0;
    seg_waddr         = clr_cnt;
    seg_wdata         = '0;
    pos_we            = 1'b0;
    mask_we           = 1'b0;
    mask_waddr        = new_entry;
    mask_wdata        = cur_bit;
    val_we            = 1'b0;
    val_waddr         = VAW'(new_entry) * VAW'(VALUES_PER_CELL) + VAW'(cur_mi);
    cur_next          = cur;
    clr_cnt_next      = clr_cnt;
    entries_used_next = entries_used;
    last_pos_next     = last_pos;
    any_loaded_next   = any_loaded;
    cur_mask_next     = cur_mask;
    lo_next           = lo;
    hi_next           = hi;
    mid_next          = mid;
    run_sum_next      = run_sum;
    run_found_next    = run_found;
    run_sat_next      = run_sat;
    out_valid_next    = out_valid && !pop;
    out_sum_next      = out_sum;
    out_null_next     = out_null;
    out_sat_next      = out_sat;
    case (state)
      sclsum_pkg::ST_INIT: begin
        // Clearing pass over the segment table.
        seg_we       = 1'b1;
        clr_cnt_next = clr_cnt + SW'(1);
      end
      sclsum_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_next  = q_item;
          seg_raddr = in_seg;
          if (q_item.kind == sclsum_pkg::OP_LOAD && q_item.mi_ok && any_loaded &&
              q_item.position == last_pos) begin
            // Another measure of the most recent cell.
            val_we        = 1'b1;
            val_waddr     = VAW'(last_entry) * VAW'(VALUES_PER_CELL) + VAW'(in_mi);
            mask_we       = 1'b1;
            mask_waddr    = last_entry;
            mask_wdata    = cur_mask | in_bit;
            cur_mask_next = cur_mask | in_bit;
          end
          if (q_item.kind == sclsum_pkg::OP_CLEAR) begin
            clr_cnt_next      = '0;
            entries_used_next = '0;
            last_pos_next     = '0;
            any_loaded_next   = 1'b0;
          end
        end
      end
      sclsum_pkg::ST_LOAD_SEG: begin
        // New cell: append it if its segment run is still open.
        if (seg_count == '0 || seg_end == (CW+1)'(entries_used)) begin
          seg_we            = 1'b1;
          seg_waddr         = cur_seg;
          seg_wdata         = {(seg_count == '0) ? new_entry : seg_first,
                               seg_count + CW'(1)};
          pos_we            = 1'b1;
          mask_we           = 1'b1;
          val_we            = 1'b1;
          cur_mask_next     = cur_bit;
          entries_used_next = entries_used + CW'(1);
          last_pos_next     = cur.position;
          any_loaded_next   = 1'b1;
        end
      end
      sclsum_pkg::ST_Q_SEG: begin
        lo_next   = CW'(seg_first);
        hi_next   = seg_end[CW-1:0];
        mid_next  = seg_first + EW'(seg_count >> 1);
        pos_raddr = mid_next;
      end
      sclsum_pkg::ST_Q_SEARCH: begin
        if (pos_rd != cur.position) begin
          lo_next   = step_lo;
          hi_next   = step_hi;
          mid_next  = EW'(step_mid);
          pos_raddr = EW'(step_mid);
        end
      end
      sclsum_pkg::ST_Q_HIT: begin
        // Saturating add of a non-null hit.
        if (mask_rd[cur_mi] && !val_rd[DW]) begin
          run_found_next = 1'b1;
          if (add_full[DW] != add_full[DW-1]) begin
            run_sum_next = add_full[DW] ? sclsum_pkg::SUM_MIN : sclsum_pkg::SUM_MAX;
            run_sat_next = 1'b1;
          end else begin
            run_sum_next = add_full[DW-1:0];
          end
        end
      end
      sclsum_pkg::ST_Q_DONE: begin
        if (cur.last && (!out_valid || pop)) begin
          out_valid_next = 1'b1;
          out_sum_next   = run_found ? run_sum : '0;
          out_null_next  = !run_found;
          out_sat_next   = run_sat;
          run_sum_next   = '0;
          run_found_next = 1'b0;
          run_sat_next   = 1'b0;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Memory ports with registered read data.
  always_ff @(posedge clk) begin
    seg_rd  <= seg_mem[seg_raddr];
    pos_rd  <= pos_mem[pos_raddr];
    mask_rd <= mask_mem[pos_raddr];
    val_rd  <= val_mem[val_raddr];
    if (seg_we) begin
      seg_mem[seg_waddr] <= seg_wdata;
    end
    if (pos_we) begin
      pos_mem[new_entry] <= cur.position;
    end
    if (mask_we) begin
      mask_mem[mask_waddr] <= mask_wdata;
    end
    if (val_we) begin
      val_mem[val_waddr] <= (state == sclsum_pkg::ST_IDLE) ?
                            {q_item.value_null, q_item.value} :
                            {cur.value_null, cur.value};
    end
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    cur      <= cur_next;
    cur_mask <= cur_mask_next;
    lo       <= lo_next;
    hi       <= hi_next;
    mid      <= mid_next;
    out_sum  <= out_sum_next;
    out_null <= out_null_next;
    out_sat  <= out_sat_next;
    if (rst) begin
      state        <= sclsum_pkg::ST_INIT;
      clr_cnt      <= '0;
      entries_used <= '0;
      last_pos     <= '0;
      any_loaded   <= 1'b0;
      run_sum      <= '0;
      run_found    <= 1'b0;
      run_sat      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      clr_cnt      <= clr_cnt_next;
      entries_used <= entries_used_next;
      last_pos     <= last_pos_next;
      any_loaded   <= any_loaded_next;
      run_sum      <= run_sum_next;
      run_found    <= run_found_next;
      run_sat      <= run_sat_next;
      out_valid    <= out_valid_next;
    end
  end

endmodule
